@@ rtl/core/pjvs_pkg.sv @@
package pjvs_pkg;

	// Every internal value is a signed Q15.16 number.
	typedef logic signed [31:0] fx_t;
	typedef logic [2:0][31:0] vec3_t;
	typedef logic [2:0][2:0][31:0] mat3_t;

	localparam int unsigned PART_W = 21;
	localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
	localparam fx_t FX_MIN = 32'sh8000_0000;

	localparam logic [15:0] STEP_TIME_RST = 16'd1092;
	localparam logic [15:0] STIFFNESS_RST = 16'd26214;
	localparam logic [16:0] DAMPING_RST = 17'd65470;

	typedef enum logic [1:0] {
		REG_STEP_TIME = 2'd0,
		REG_STIFFNESS = 2'd1,
		REG_DAMPING = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] orient;
		logic [62:0] offset;
		logic [62:0] pos;
		logic [62:0] anchor;
		logic [62:0] linv;
		logic [62:0] angv;
		logic [62:0] irow0;
		logic [62:0] irow1;
		logic [62:0] irow2;
		logic [31:0] mass;
	} jin_t;

	typedef struct packed {
		jin_t raw;
		fx_t invm;
		fx_t gain;
		logic m0;
	} jnt_t;

	typedef struct packed {
		jnt_t j;
		vec3_t r;
		vec3_t cp;
		vec3_t cv;
		mat3_t a;
		fx_t det;
		logic fault;
	} geo_t;

	function automatic fx_t fx_sat(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return FX_MAX;
		end else if (x < -64'sd2147483648) begin
			return FX_MIN;
		end
		return x[31:0];
	endfunction

	function automatic fx_t fx_add(input fx_t a, input fx_t b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return fx_sat(s);
	endfunction

	function automatic fx_t fx_sub(input fx_t a, input fx_t b);
		logic signed [63:0] s;
		s = 64'(a) - 64'(b);
		return fx_sat(s);
	endfunction

	function automatic fx_t fx_neg(input fx_t a);
		return fx_sub(32'sd0, a);
	endfunction

	function automatic fx_t fx_sum3(input fx_t a, input fx_t b, input fx_t c);
		return fx_add(fx_add(a, b), c);
	endfunction

	// Product shifted right by s with round half up, then saturated.
	function automatic fx_t fx_mul(input fx_t a, input fx_t b, input int unsigned s);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + (64'sd1 <<< (s - 1));
		return fx_sat(p >>> s);
	endfunction

	// Q10.10 part of a packed word, widened to Q15.16.
	function automatic fx_t vel(input logic [62:0] w, input int idx);
		logic [20:0] b;
		b = w[PART_W * idx +: PART_W];
		return {{5{b[20]}}, b, 6'b0};
	endfunction

	function automatic fx_t inert(input logic [62:0] w, input int idx);
		logic [20:0] b;
		b = w[PART_W * idx +: PART_W];
		return {{11{b[20]}}, b};
	endfunction

	function automatic fx_t irow(input jin_t raw, input int k, input int j);
		logic [62:0] w;
		case (k)
			0: w = raw.irow0;
			1: w = raw.irow1;
			default: w = raw.irow2;
		endcase
		return inert(w, j);
	endfunction

	function automatic fx_t quat(input logic [63:0] q, input int idx);
		logic [15:0] h;
		h = q[16 * idx +: 16];
		return {{16{h[15]}}, h};
	endfunction

	// Entry (i, k) of the skew matrix of r.
	function automatic fx_t skew(input vec3_t r, input int i, input int k);
		fx_t res;
		res = '0;
		if (i == 0 && k == 1) begin
			res = r[2];
		end else if (i == 0 && k == 2) begin
			res = fx_neg(r[1]);
		end else if (i == 1 && k == 0) begin
			res = fx_neg(r[2]);
		end else if (i == 1 && k == 2) begin
			res = r[0];
		end else if (i == 2 && k == 0) begin
			res = r[1];
		end else if (i == 2 && k == 1) begin
			res = fx_neg(r[0]);
		end
		return res;
	endfunction

endpackage

@@ rtl/core/point_joint_velocity_solver_top.sv @@
// Ball-socket joint velocity solver. Each request on the slave stream is one joint and
// yields exactly one result on the master stream, in order. The datapath is a single
// pipeline of 107 register stages: a 34-stage divider for the inverse mass and the
// Baumgarte gain, 13 stages for the rotation, errors, effective mass and its adjugate,
// five for the impulse numerators, a 48-stage divider by the determinant and seven for
// the velocity update, damping and packing. A new joint is taken in every cycle in which
// the master side does not stall, so the rate is one joint per clock; the whole pipeline
// holds while a result waits on the master side. Write the registers through the plain
// write port only while no joint is in flight; the block itself does not enforce this.
module point_joint_velocity_solver_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// From bit 0: orientation_wxyz, local_offset_xyz, body_position_xyz,
	// anchor_position_xyz, linear_velocity_xyz, angular_velocity_xyz,
	// inertia_row_zero, inertia_row_one, inertia_row_two, body_mass.
	input  logic [599:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// From bit 0: new_linear_velocity_xyz, new_angular_velocity_xyz, two zero bits.
	output logic [127:0] m_axis_tdata,
	// Bit 0: fault.
	output logic [0:0]   m_axis_tuser
);

	localparam int JIN_W = $bits(pjvs_pkg::jin_t);

	logic [15:0] step_q;
	logic [15:0] stiff_q;
	logic [16:0] damp_q;
	logic en;
	pjvs_pkg::jin_t jin;
	pjvs_pkg::jin_t jin_d;
	pjvs_pkg::jnt_t jnt;
	logic [15:0] dt;
	logic [33:0] inv_num;
	logic [33:0] gain_num;
	logic [33:0] inv_quo;
	logic [33:0] gain_quo;
	logic vld_inv;
	logic vld_gain;
	logic m0_d;
	logic geo_vld;
	pjvs_pkg::geo_t geo;
	logic [62:0] lin_vel;
	logic [62:0] ang_vel;
	logic fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pjvs_pkg::STEP_TIME_RST;
			stiff_q <= pjvs_pkg::STIFFNESS_RST;
			damp_q <= pjvs_pkg::DAMPING_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pjvs_pkg::REG_STEP_TIME: step_q <= cfg_wr_data[15:0];
				pjvs_pkg::REG_STIFFNESS: stiff_q <= cfg_wr_data[15:0];
				pjvs_pkg::REG_DAMPING: damp_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		jin.orient = s_axis_tdata[63:0];
		jin.offset = s_axis_tdata[126:64];
		jin.pos = s_axis_tdata[189:127];
		jin.anchor = s_axis_tdata[252:190];
		jin.linv = s_axis_tdata[315:253];
		jin.angv = s_axis_tdata[378:316];
		jin.irow0 = s_axis_tdata[441:379];
		jin.irow1 = s_axis_tdata[504:442];
		jin.irow2 = s_axis_tdata[567:505];
		jin.mass = s_axis_tdata[599:568];
	end

	// A zero step time counts as one.
	assign dt = (step_q == 16'd0) ? 16'd1 : step_q;
	assign inv_num = 34'h1_0000_0000 + {3'b0, jin.mass[31:1]};
	assign gain_num = {stiff_q, 18'b0} + {19'b0, dt[15:1]};

	pjvs_div #(.NW(34), .DW(32), .PW(JIN_W)) u_div_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.num     (inv_num),
		.den     (jin.mass),
		.pay     (jin),
		.out_vld (vld_inv),
		.quo     (inv_quo),
		.out_pay (jin_d)
	);

	pjvs_div #(.NW(34), .DW(16), .PW(1)) u_div_gain (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.num     (gain_num),
		.den     (dt),
		.pay     (jin.mass == 32'd0),
		.out_vld (vld_gain),
		.quo     (gain_quo),
		.out_pay (m0_d)
	);

	always_comb begin
		jnt.raw = jin_d;
		jnt.m0 = m0_d;
		jnt.invm = (inv_quo > 34'h0_7FFF_FFFF) ? pjvs_pkg::FX_MAX : inv_quo[31:0];
		jnt.gain = (gain_quo > 34'h0_7FFF_FFFF) ? pjvs_pkg::FX_MAX : gain_quo[31:0];
	end

	pjvs_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_inv && vld_gain),
		.in_jnt  (jnt),
		.out_vld (geo_vld),
		.out_geo (geo)
	);

	pjvs_impulse u_impulse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (geo_vld),
		.in_geo  (geo),
		.damping (damp_q),
		.out_vld (m_axis_tvalid),
		.lin_vel (lin_vel),
		.ang_vel (ang_vel),
		.fault   (fault)
	);

	assign m_axis_tdata = {2'b00, ang_vel, lin_vel};
	assign m_axis_tuser = fault;

endmodule

@@ rtl/core/pjvs_div.sv @@
module pjvs_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] n_s [NW];
	logic [NW-1:0] q_s [NW];
	logic [DW-1:0] d_s [NW];
	logic [PW-1:0] p_s [NW];

	// Restoring division, one quotient bit per stage from the top down.
	for (genvar k = 0; k < NW; k++) begin : g_st
		logic          v_i;
		logic [DW-1:0] rem_i;
		logic [NW-1:0] n_i;
		logic [NW-1:0] q_i;
		logic [DW-1:0] d_i;
		logic [PW-1:0] p_i;
		logic [DW:0]   t;

		if (k == 0) begin : g_first
			assign v_i = in_vld;
			assign rem_i = '0;
			assign n_i = num;
			assign q_i = '0;
			assign d_i = den;
			assign p_i = pay;
		end else begin : g_next
			assign v_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign n_i = n_s[k-1];
			assign q_i = q_s[k-1];
			assign d_i = d_s[k-1];
			assign p_i = p_s[k-1];
		end

		assign t = {rem_i, n_i[NW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, d_i}) begin
					rem_s[k] <= DW'(t - {1'b0, d_i});
					q_s[k] <= {q_i[NW-2:0], 1'b1};
				end else begin
					rem_s[k] <= t[DW-1:0];
					q_s[k] <= {q_i[NW-2:0], 1'b0};
				end
				n_s[k] <= {n_i[NW-2:0], 1'b0};
				d_s[k] <= d_i;
				p_s[k] <= p_i;
			end
		end
	end

	assign out_vld = vld_s[NW-1];
	assign quo = q_s[NW-1];
	assign out_pay = p_s[NW-1];

endmodule

@@ rtl/core/pjvs_geom.sv @@
module pjvs_geom (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  pjvs_pkg::jnt_t  in_jnt,
	output logic            out_vld,
	output pjvs_pkg::geo_t  out_geo
);

	typedef logic [2:0][2:0][2:0][31:0] cube_t;

	logic [13:1] vld_s;
	pjvs_pkg::geo_t g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7;
	pjvs_pkg::geo_t g_s8, g_s9, g_s10, g_s11, g_s12, g_s13;
	logic [8:0][31:0] qp_s1;
	pjvs_pkg::mat3_t rot_c, rm_s2, re_s3, m_s7, k_s9, a_c;
	logic [5:0][31:0] wr_s5;
	cube_t mp_s6, kp_s8;
	logic [8:0][1:0][31:0] ap_s10;
	pjvs_pkg::vec3_t k0_s10, k0_s11, dp_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[12:1], in_vld};
		end
	end

	// Quaternion products in the order xx yy zz xy xz yz wx wy wz.
	always_ff @(posedge clk) begin
		pjvs_pkg::geo_t nx;
		if (en) begin
			nx = '0;
			nx.j = in_jnt;
			g_s1 <= nx;
			qp_s1[0] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 1),
				pjvs_pkg::quat(in_jnt.raw.orient, 1), 12);
			qp_s1[1] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 2),
				pjvs_pkg::quat(in_jnt.raw.orient, 2), 12);
			qp_s1[2] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 3),
				pjvs_pkg::quat(in_jnt.raw.orient, 3), 12);
			qp_s1[3] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 1),
				pjvs_pkg::quat(in_jnt.raw.orient, 2), 12);
			qp_s1[4] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 1),
				pjvs_pkg::quat(in_jnt.raw.orient, 3), 12);
			qp_s1[5] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 2),
				pjvs_pkg::quat(in_jnt.raw.orient, 3), 12);
			qp_s1[6] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 0),
				pjvs_pkg::quat(in_jnt.raw.orient, 1), 12);
			qp_s1[7] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 0),
				pjvs_pkg::quat(in_jnt.raw.orient, 2), 12);
			qp_s1[8] <= pjvs_pkg::fx_mul(pjvs_pkg::quat(in_jnt.raw.orient, 0),
				pjvs_pkg::quat(in_jnt.raw.orient, 3), 12);
		end
	end

	always_comb begin
		pjvs_pkg::fx_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
		xx = qp_s1[0];
		yy = qp_s1[1];
		zz = qp_s1[2];
		xy = qp_s1[3];
		xz = qp_s1[4];
		yz = qp_s1[5];
		wx = qp_s1[6];
		wy = qp_s1[7];
		wz = qp_s1[8];
		rot_c[0][0] = 32'sd65536 - 32'sd2 * (yy + zz);
		rot_c[0][1] = 32'sd2 * (xy - wz);
		rot_c[0][2] = 32'sd2 * (xz + wy);
		rot_c[1][0] = 32'sd2 * (xy + wz);
		rot_c[1][1] = 32'sd65536 - 32'sd2 * (xx + zz);
		rot_c[1][2] = 32'sd2 * (yz - wx);
		rot_c[2][0] = 32'sd2 * (xz - wy);
		rot_c[2][1] = 32'sd2 * (yz + wx);
		rot_c[2][2] = 32'sd65536 - 32'sd2 * (xx + yy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2 <= g_s1;
			rm_s2 <= rot_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s3 <= g_s2;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					re_s3[i][j] <= pjvs_pkg::fx_mul(rm_s2[i][j],
						pjvs_pkg::vel(g_s2.j.raw.offset, j), 16);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pjvs_pkg::geo_t nx;
		if (en) begin
			nx = g_s3;
			for (int i = 0; i < 3; i++) begin
				nx.r[i] = pjvs_pkg::fx_sum3(re_s3[i][0], re_s3[i][1], re_s3[i][2]);
			end
			g_s4 <= nx;
		end
	end

	// Position error and the cross product terms of w x r.
	always_ff @(posedge clk) begin
		pjvs_pkg::geo_t nx;
		if (en) begin
			nx = g_s4;
			for (int i = 0; i < 3; i++) begin
				nx.cp[i] = pjvs_pkg::fx_sub(
					pjvs_pkg::fx_add(pjvs_pkg::vel(g_s4.j.raw.pos, i), g_s4.r[i]),
					pjvs_pkg::vel(g_s4.j.raw.anchor, i));
			end
			g_s5 <= nx;
			wr_s5[0] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 1), g_s4.r[2], 16);
			wr_s5[1] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 2), g_s4.r[1], 16);
			wr_s5[2] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 2), g_s4.r[0], 16);
			wr_s5[3] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 0), g_s4.r[2], 16);
			wr_s5[4] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 0), g_s4.r[1], 16);
			wr_s5[5] <= pjvs_pkg::fx_mul(pjvs_pkg::vel(g_s4.j.raw.angv, 1), g_s4.r[0], 16);
		end
	end

	always_ff @(posedge clk) begin
		pjvs_pkg::geo_t nx;
		if (en) begin
			nx = g_s5;
			for (int i = 0; i < 3; i++) begin
				nx.cv[i] = pjvs_pkg::fx_add(pjvs_pkg::vel(g_s5.j.raw.linv, i),
					pjvs_pkg::fx_sub(wr_s5[2*i], wr_s5[2*i+1]));
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						mp_s6[i][j][k] <= pjvs_pkg::fx_mul(pjvs_pkg::skew(g_s5.r, i, k),
							pjvs_pkg::irow(g_s5.j.raw, k, j), 15);
					end
				end
			end
			g_s6 <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7 <= g_s6;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s7[i][j] <= pjvs_pkg::fx_sum3(mp_s6[i][j][0], mp_s6[i][j][1],
						mp_s6[i][j][2]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s8 <= g_s7;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						kp_s8[i][j][k] <= pjvs_pkg::fx_mul(m_s7[i][k],
							pjvs_pkg::skew(g_s7.r, j, k), 16);
					end
				end
			end
		end
	end

	// The inverse mass joins the diagonal after the sum of products.
	always_ff @(posedge clk) begin
		if (en) begin
			g_s9 <= g_s8;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (i == j) begin
						k_s9[i][j] <= pjvs_pkg::fx_add(pjvs_pkg::fx_sum3(kp_s8[i][j][0],
							kp_s8[i][j][1], kp_s8[i][j][2]), g_s8.j.invm);
					end else begin
						k_s9[i][j] <= pjvs_pkg::fx_sum3(kp_s8[i][j][0], kp_s8[i][j][1],
							kp_s8[i][j][2]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s10 <= g_s9;
			k0_s10 <= k_s9[0];
			ap_s10[0][0] <= pjvs_pkg::fx_mul(k_s9[1][1], k_s9[2][2], 16);
			ap_s10[0][1] <= pjvs_pkg::fx_mul(k_s9[1][2], k_s9[2][1], 16);
			ap_s10[1][0] <= pjvs_pkg::fx_mul(k_s9[0][2], k_s9[2][1], 16);
			ap_s10[1][1] <= pjvs_pkg::fx_mul(k_s9[0][1], k_s9[2][2], 16);
			ap_s10[2][0] <= pjvs_pkg::fx_mul(k_s9[0][1], k_s9[1][2], 16);
			ap_s10[2][1] <= pjvs_pkg::fx_mul(k_s9[0][2], k_s9[1][1], 16);
			ap_s10[3][0] <= pjvs_pkg::fx_mul(k_s9[1][2], k_s9[2][0], 16);
			ap_s10[3][1] <= pjvs_pkg::fx_mul(k_s9[1][0], k_s9[2][2], 16);
			ap_s10[4][0] <= pjvs_pkg::fx_mul(k_s9[0][0], k_s9[2][2], 16);
			ap_s10[4][1] <= pjvs_pkg::fx_mul(k_s9[0][2], k_s9[2][0], 16);
			ap_s10[5][0] <= pjvs_pkg::fx_mul(k_s9[0][2], k_s9[1][0], 16);
			ap_s10[5][1] <= pjvs_pkg::fx_mul(k_s9[0][0], k_s9[1][2], 16);
			ap_s10[6][0] <= pjvs_pkg::fx_mul(k_s9[1][0], k_s9[2][1], 16);
			ap_s10[6][1] <= pjvs_pkg::fx_mul(k_s9[1][1], k_s9[2][0], 16);
			ap_s10[7][0] <= pjvs_pkg::fx_mul(k_s9[0][1], k_s9[2][0], 16);
			ap_s10[7][1] <= pjvs_pkg::fx_mul(k_s9[0][0], k_s9[2][1], 16);
			ap_s10[8][0] <= pjvs_pkg::fx_mul(k_s9[0][0], k_s9[1][1], 16);
			ap_s10[8][1] <= pjvs_pkg::fx_mul(k_s9[0][1], k_s9[1][0], 16);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				a_c[i][j] = pjvs_pkg::fx_sub(ap_s10[3*i+j][0], ap_s10[3*i+j][1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		pjvs_pkg::geo_t nx;
		if (en) begin
			nx = g_s10;
			nx.a = a_c;
			g_s11 <= nx;
			k0_s11 <= k0_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s12 <= g_s11;
			for (int k = 0; k < 3; k++) begin
				dp_s12[k] <= pjvs_pkg::fx_mul(k0_s11[k], g_s11.a[k][0], 16);
			end
		end
	end

	always_ff @(posedge clk) begin
		pjvs_pkg::fx_t det;
		pjvs_pkg::geo_t nx;
		if (en) begin
			det = pjvs_pkg::fx_sum3(dp_s12[0], dp_s12[1], dp_s12[2]);
			nx = g_s12;
			nx.det = det;
			nx.fault = g_s12.j.m0 || (det == 32'sd0);
			g_s13 <= nx;
		end
	end

	assign out_vld = vld_s[13];
	assign out_geo = g_s13;

endmodule

@@ rtl/core/pjvs_impulse.sv @@
module pjvs_impulse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  pjvs_pkg::geo_t  in_geo,
	input  logic [16:0]     damping,
	output logic            out_vld,
	output logic [62:0]     lin_vel,
	output logic [62:0]     ang_vel,
	output logic            fault
);

	localparam int NUM_W = 48;
	localparam int GEO_W = $bits(pjvs_pkg::geo_t);

	logic [5:1] vlda_s;
	logic [12:6] vldb_s;
	pjvs_pkg::geo_t g_s1, g_s2, g_s3, g_s4, g_s5, g_d, g_s6, g_s7, g_s8, g_s9;
	pjvs_pkg::geo_t g_s10, g_s11;
	pjvs_pkg::vec3_t fc_s1, b_s2, acc_s4, lam_s6, dv_s7, t_s8, vv_s8, vv_s9, vv_s10;
	pjvs_pkg::vec3_t ww_s10, nv_s11, nw_s11;
	pjvs_pkg::mat3_t abp_s3, tp_s7, itp_s9;
	logic [2:0][NUM_W-1:0] num_s5;
	logic [31:0] den_s5;
	logic [2:0] sgn_s5;
	logic [2:0] dvld;
	logic [2:0][NUM_W-1:0] quo;
	logic [2:0] sgn_d;
	logic [62:0] lin_s12, ang_s12;
	logic fault_s12;
	pjvs_pkg::fx_t dmp;

	function automatic pjvs_pkg::fx_t lam_of(input logic [NUM_W-1:0] q, input logic neg);
		logic [31:0] m;
		m = (q >= NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : q[31:0];
		if (neg) begin
			return -m;
		end else if (m == 32'h8000_0000) begin
			return pjvs_pkg::FX_MAX;
		end
		return m;
	endfunction

	// Back to Q10.10 with round half up, clipped to 21 bits.
	function automatic logic [62:0] pack3(input pjvs_pkg::vec3_t x);
		logic [62:0] w;
		logic signed [32:0] y;
		pjvs_pkg::fx_t e;
		w = '0;
		for (int i = 0; i < 3; i++) begin
			e = x[i];
			y = (33'(e) + 33'sd32) >>> 6;
			if (y > 33'sd1048575) begin
				w[21*i +: 21] = 21'h0F_FFFF;
			end else if (y < -33'sd1048576) begin
				w[21*i +: 21] = 21'h10_0000;
			end else begin
				w[21*i +: 21] = y[20:0];
			end
		end
		return w;
	endfunction

	assign dmp = {15'b0, damping};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlda_s <= '0;
			vldb_s <= '0;
		end else if (en) begin
			vlda_s <= {vlda_s[4:1], in_vld};
			vldb_s <= {vldb_s[11:6], &dvld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= in_geo;
			for (int i = 0; i < 3; i++) begin
				fc_s1[i] <= pjvs_pkg::fx_mul(in_geo.j.gain, in_geo.cp[i], 16);
			end
			g_s2 <= g_s1;
			for (int i = 0; i < 3; i++) begin
				b_s2[i] <= pjvs_pkg::fx_sub(pjvs_pkg::fx_neg(g_s1.cv[i]), fc_s1[i]);
			end
			g_s3 <= g_s2;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					abp_s3[i][j] <= pjvs_pkg::fx_mul(g_s2.a[i][j], b_s2[j], 16);
				end
			end
			g_s4 <= g_s3;
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= pjvs_pkg::fx_sum3(abp_s3[i][0], abp_s3[i][1], abp_s3[i][2]);
			end
		end
	end

	// Magnitudes and signs for the impulse division.
	always_ff @(posedge clk) begin
		pjvs_pkg::fx_t a;
		pjvs_pkg::fx_t d;
		logic [31:0] an;
		logic [31:0] ad;
		if (en) begin
			g_s5 <= g_s4;
			d = g_s4.det;
			ad = (d < 0) ? -d : d;
			den_s5 <= ad;
			for (int i = 0; i < 3; i++) begin
				a = acc_s4[i];
				an = (a < 0) ? -a : a;
				num_s5[i] <= {an, 16'b0} + {17'b0, ad[31:1]};
				sgn_s5[i] <= (a < 0) != (d < 0);
			end
		end
	end

	pjvs_div #(.NW(NUM_W), .DW(32), .PW(GEO_W + 1)) u_div0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vlda_s[5]),
		.num     (num_s5[0]),
		.den     (den_s5),
		.pay     ({g_s5, sgn_s5[0]}),
		.out_vld (dvld[0]),
		.quo     (quo[0]),
		.out_pay ({g_d, sgn_d[0]})
	);

	pjvs_div #(.NW(NUM_W), .DW(32), .PW(1)) u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vlda_s[5]),
		.num     (num_s5[1]),
		.den     (den_s5),
		.pay     (sgn_s5[1]),
		.out_vld (dvld[1]),
		.quo     (quo[1]),
		.out_pay (sgn_d[1])
	);

	pjvs_div #(.NW(NUM_W), .DW(32), .PW(1)) u_div2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vlda_s[5]),
		.num     (num_s5[2]),
		.den     (den_s5),
		.pay     (sgn_s5[2]),
		.out_vld (dvld[2]),
		.quo     (quo[2]),
		.out_pay (sgn_d[2])
	);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s6 <= g_d;
			for (int i = 0; i < 3; i++) begin
				lam_s6[i] <= lam_of(quo[i], sgn_d[i]);
			end
			g_s7 <= g_s6;
			for (int i = 0; i < 3; i++) begin
				dv_s7[i] <= pjvs_pkg::fx_mul(g_s6.j.invm, lam_s6[i], 16);
				for (int k = 0; k < 3; k++) begin
					tp_s7[i][k] <= pjvs_pkg::fx_mul(pjvs_pkg::skew(g_s6.r, k, i),
						lam_s6[k], 16);
				end
			end
			g_s8 <= g_s7;
			for (int i = 0; i < 3; i++) begin
				t_s8[i] <= pjvs_pkg::fx_sum3(tp_s7[i][0], tp_s7[i][1], tp_s7[i][2]);
				vv_s8[i] <= pjvs_pkg::fx_add(pjvs_pkg::vel(g_s7.j.raw.linv, i), dv_s7[i]);
			end
			g_s9 <= g_s8;
			vv_s9 <= vv_s8;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					itp_s9[i][j] <= pjvs_pkg::fx_mul(pjvs_pkg::irow(g_s8.j.raw, i, j),
						t_s8[j], 15);
				end
			end
			g_s10 <= g_s9;
			vv_s10 <= vv_s9;
			for (int i = 0; i < 3; i++) begin
				ww_s10[i] <= pjvs_pkg::fx_add(pjvs_pkg::vel(g_s9.j.raw.angv, i),
					pjvs_pkg::fx_sum3(itp_s9[i][0], itp_s9[i][1], itp_s9[i][2]));
			end
			g_s11 <= g_s10;
			for (int i = 0; i < 3; i++) begin
				nv_s11[i] <= pjvs_pkg::fx_mul(vv_s10[i], dmp, 16);
				nw_s11[i] <= pjvs_pkg::fx_mul(ww_s10[i], dmp, 16);
			end
			// A faulted joint hands its input velocities back untouched.
			lin_s12 <= g_s11.fault ? g_s11.j.raw.linv : pack3(nv_s11);
			ang_s12 <= g_s11.fault ? g_s11.j.raw.angv : pack3(nw_s11);
			fault_s12 <= g_s11.fault;
		end
	end

	assign out_vld = vldb_s[12];
	assign lin_vel = lin_s12;
	assign ang_vel = ang_s12;
	assign fault = fault_s12;

endmodule

@@ tb/pjvs_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port, works out each joint's result and
// compares it with what the solver returns, oldest request first.
module pjvs_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [599:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	output int           fail_count,
	output int           pending,
	output int           fault_count,
	output int           result_count
);

	typedef struct {
		logic [62:0] lin;
		logic [62:0] ang;
		logic        fault;
	} joint_result_t;

	joint_result_t expected_q[$];
	logic [15:0] step_time_q;
	logic [15:0] stiffness_q;
	logic [16:0] damping_q;

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint round_shift(input longint x, input int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint fmul(input longint a, input longint b, input int s);
		return clamp32(round_shift(a * b, s));
	endfunction

	function automatic longint fadd(input longint a, input longint b);
		return clamp32(a + b);
	endfunction

	function automatic longint fsub(input longint a, input longint b);
		return clamp32(a - b);
	endfunction

	function automatic longint quot(input longint n, input longint d);
		longint an;
		longint ad;
		longint q;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = ((an <<< 16) + (ad >>> 1)) / ad;
		if (q > 64'sd2147483648) q = 64'sd2147483648;
		if ((n < 0) != (d < 0)) q = -q;
		return clamp32(q);
	endfunction

	function automatic longint part21(input logic [62:0] w, input int i);
		logic signed [20:0] b;
		b = w[21 * i +: 21];
		return longint'(b);
	endfunction

	function automatic logic [62:0] pack_q10(input longint x[3]);
		logic [62:0] w;
		longint y;
		w = '0;
		for (int i = 0; i < 3; i++) begin
			y = round_shift(x[i], 6);
			if (y > 1048575) y = 1048575;
			if (y < -1048576) y = -1048576;
			w[21 * i +: 21] = y[20:0];
		end
		return w;
	endfunction

	function automatic joint_result_t solve_joint(input logic [599:0] d);
		joint_result_t res;
		longint q[4];
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint rot[3][3], iinv[3][3], sk[3][3], sm[3][3], kk[3][3], adj[3][3];
		longint e[3], r[3], p[3], an[3], v[3], w[3], cp[3], cv[3], b[3];
		longint lam[3], t[3], nv[3], nw[3];
		longint invm, gain, det, acc, dv, mass, dt;
		logic [62:0] fld[8];
		for (int i = 0; i < 8; i++) fld[i] = d[64 + 63 * i +: 63];
		mass = longint'(d[599:568]);
		for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[16 * i +: 16]));
		xx = round_shift(q[1] * q[1], 12); yy = round_shift(q[2] * q[2], 12);
		zz = round_shift(q[3] * q[3], 12); xy = round_shift(q[1] * q[2], 12);
		xz = round_shift(q[1] * q[3], 12); yz = round_shift(q[2] * q[3], 12);
		wx = round_shift(q[0] * q[1], 12); wy = round_shift(q[0] * q[2], 12);
		wz = round_shift(q[0] * q[3], 12);
		rot[0][0] = 65536 - 2 * (yy + zz); rot[0][1] = 2 * (xy - wz); rot[0][2] = 2 * (xz + wy);
		rot[1][0] = 2 * (xy + wz); rot[1][1] = 65536 - 2 * (xx + zz); rot[1][2] = 2 * (yz - wx);
		rot[2][0] = 2 * (xz - wy); rot[2][1] = 2 * (yz + wx); rot[2][2] = 65536 - 2 * (xx + yy);
		for (int i = 0; i < 3; i++) begin
			e[i] = part21(fld[0], i) * 64;
			p[i] = part21(fld[1], i) * 64;
			an[i] = part21(fld[2], i) * 64;
			v[i] = part21(fld[3], i) * 64;
			w[i] = part21(fld[4], i) * 64;
			iinv[0][i] = part21(fld[5], i);
			iinv[1][i] = part21(fld[6], i);
			iinv[2][i] = part21(fld[7], i);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc = fadd(acc, fmul(rot[i][j], e[j], 16));
			r[i] = acc;
		end
		for (int i = 0; i < 3; i++) cp[i] = fsub(fadd(p[i], r[i]), an[i]);
		cv[0] = fadd(v[0], fsub(fmul(w[1], r[2], 16), fmul(w[2], r[1], 16)));
		cv[1] = fadd(v[1], fsub(fmul(w[2], r[0], 16), fmul(w[0], r[2], 16)));
		cv[2] = fadd(v[2], fsub(fmul(w[0], r[1], 16), fmul(w[1], r[0], 16)));
		sk[0][0] = 0; sk[0][1] = r[2]; sk[0][2] = clamp32(-r[1]);
		sk[1][0] = clamp32(-r[2]); sk[1][1] = 0; sk[1][2] = r[0];
		sk[2][0] = r[1]; sk[2][1] = clamp32(-r[0]); sk[2][2] = 0;
		if (mass != 0) begin
			invm = ((64'sd1 <<< 32) + (mass >>> 1)) / mass;
			if (invm > 64'sd2147483647) invm = 64'sd2147483647;
		end else begin
			invm = 0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc = fadd(acc, fmul(sk[i][k], iinv[k][j], 15));
				sm[i][j] = acc;
			end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc = fadd(acc, fmul(sm[i][k], sk[j][k], 16));
				kk[i][j] = (i == j) ? fadd(acc, invm) : acc;
			end
		adj[0][0] = fsub(fmul(kk[1][1], kk[2][2], 16), fmul(kk[1][2], kk[2][1], 16));
		adj[0][1] = fsub(fmul(kk[0][2], kk[2][1], 16), fmul(kk[0][1], kk[2][2], 16));
		adj[0][2] = fsub(fmul(kk[0][1], kk[1][2], 16), fmul(kk[0][2], kk[1][1], 16));
		adj[1][0] = fsub(fmul(kk[1][2], kk[2][0], 16), fmul(kk[1][0], kk[2][2], 16));
		adj[1][1] = fsub(fmul(kk[0][0], kk[2][2], 16), fmul(kk[0][2], kk[2][0], 16));
		adj[1][2] = fsub(fmul(kk[0][2], kk[1][0], 16), fmul(kk[0][0], kk[1][2], 16));
		adj[2][0] = fsub(fmul(kk[1][0], kk[2][1], 16), fmul(kk[1][1], kk[2][0], 16));
		adj[2][1] = fsub(fmul(kk[0][1], kk[2][0], 16), fmul(kk[0][0], kk[2][1], 16));
		adj[2][2] = fsub(fmul(kk[0][0], kk[1][1], 16), fmul(kk[0][1], kk[1][0], 16));
		det = fadd(fadd(fmul(kk[0][0], adj[0][0], 16), fmul(kk[0][1], adj[1][0], 16)),
			fmul(kk[0][2], adj[2][0], 16));
		if (mass == 0 || det == 0) begin
			res.lin = fld[3];
			res.ang = fld[4];
			res.fault = 1'b1;
			return res;
		end
		dt = longint'(step_time_q);
		if (dt == 0) dt = 1;
		gain = ((longint'(stiffness_q) <<< 18) + (dt >>> 1)) / dt;
		if (gain > 64'sd2147483647) gain = 64'sd2147483647;
		for (int i = 0; i < 3; i++) b[i] = fsub(clamp32(-cv[i]), fmul(gain, cp[i], 16));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc = fadd(acc, fmul(adj[i][j], b[j], 16));
			lam[i] = quot(acc, det);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc = fadd(acc, fmul(sk[k][i], lam[k], 16));
			t[i] = acc;
		end
		for (int i = 0; i < 3; i++) begin
			dv = fmul(invm, lam[i], 16);
			acc = 0;
			for (int j = 0; j < 3; j++) acc = fadd(acc, fmul(iinv[i][j], t[j], 15));
			nv[i] = fmul(fadd(v[i], dv), longint'(damping_q), 16);
			nw[i] = fmul(fadd(w[i], acc), longint'(damping_q), 16);
		end
		res.lin = pack_q10(nv);
		res.ang = pack_q10(nw);
		res.fault = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		joint_result_t exp_r;
		int errs;
		if (!arst_n) begin
			step_time_q <= pjvs_pkg::STEP_TIME_RST;
			stiffness_q <= pjvs_pkg::STIFFNESS_RST;
			damping_q <= pjvs_pkg::DAMPING_RST;
			fail_count <= 0;
			fault_count <= 0;
			result_count <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			errs = 0;
			if (cfg_wr_en) begin
				case (cfg_index)
					pjvs_pkg::REG_STEP_TIME: step_time_q <= cfg_wr_data[15:0];
					pjvs_pkg::REG_STIFFNESS: stiffness_q <= cfg_wr_data[15:0];
					pjvs_pkg::REG_DAMPING: damping_q <= cfg_wr_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) expected_q.push_back(solve_joint(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					$error("result with no joint request outstanding");
					errs++;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.fault) fault_count <= fault_count + 1;
					if (m_axis_tdata[62:0] !== exp_r.lin) begin
						$error("new_linear_velocity_xyz: expected %h, got %h",
							exp_r.lin, m_axis_tdata[62:0]);
						errs++;
					end
					if (m_axis_tdata[125:63] !== exp_r.ang) begin
						$error("new_angular_velocity_xyz: expected %h, got %h",
							exp_r.ang, m_axis_tdata[125:63]);
						errs++;
					end
					if (m_axis_tuser[0] !== exp_r.fault) begin
						$error("fault: expected %b, got %b", exp_r.fault, m_axis_tuser[0]);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= expected_q.size();
		end
	end

endmodule

@@ tb/tb_point_joint_velocity_solver_top.sv @@
`timescale 1ns / 1ps

module tb_point_joint_velocity_solver_top;

	logic         clk;
	logic         arst_n;
	logic         cfg_wr_en;
	logic [1:0]   cfg_index;
	logic [16:0]  cfg_wr_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [599:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	int           fail_count;
	int           pending;
	int           fault_count;
	int           result_count;
	int           burst_left;
	int           joints_sent;
	logic         hold_off;

	point_joint_velocity_solver_top u_dut (.*);

	pjvs_checker u_checker (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: switches between four stall patterns at random; a long hold-off when asked.
	initial begin
		int rx_mode;
		int rx_cnt;
		m_axis_tready = 1'b0;
		rx_mode = 0;
		rx_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				rx_cnt++;
				if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 3) != 0);
					2: m_axis_tready = ($urandom_range(0, 1) != 0);
					default: m_axis_tready = ((rx_cnt % 8) < 3);
				endcase
			end
		end
	end

	function automatic logic [20:0] rnd_part(input int span);
		int x;
		x = int'($urandom_range(0, 2 * span)) - span;
		return x[20:0];
	endfunction

	function automatic logic [62:0] rnd_vec(input int span);
		return {rnd_part(span), rnd_part(span), rnd_part(span)};
	endfunction

	function automatic logic [63:0] rnd_bits64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [599:0] make_joint(input logic [63:0] q, input logic [62:0] off,
			input logic [62:0] pos, input logic [62:0] anc, input logic [62:0] lv,
			input logic [62:0] av, input logic [62:0] i0, input logic [62:0] i1,
			input logic [62:0] i2, input logic [31:0] m);
		return {m, i2, i1, i0, av, lv, anc, pos, off, q};
	endfunction

	// A plausible joint: unnormalised random orientation, mostly diagonal inertia, moderate mass.
	function automatic logic [599:0] plausible_joint();
		logic [15:0] qc[4];
		logic [62:0] irows[3];
		for (int i = 0; i < 4; i++) qc[i] = 16'(rnd_part(12000));
		for (int i = 0; i < 3; i++) begin
			irows[i] = rnd_vec(1500);
			irows[i][21 * i +: 21] = 21'($urandom_range(2000, 80000));
		end
		return make_joint({qc[3], qc[2], qc[1], qc[0]}, rnd_vec(20000), rnd_vec(90000),
			rnd_vec(90000), rnd_vec(30000), rnd_vec(30000), irows[0], irows[1], irows[2],
			32'($urandom_range(1 << 12, 1 << 24)));
	endfunction

	function automatic logic [599:0] noise_joint();
		return make_joint(rnd_bits64(), 63'(rnd_bits64()), 63'(rnd_bits64()),
			63'(rnd_bits64()), 63'(rnd_bits64()), 63'(rnd_bits64()), 63'(rnd_bits64()),
			63'(rnd_bits64()), 63'(rnd_bits64()), $urandom());
	endfunction

	task automatic send_joint(input logic [599:0] d);
		s_axis_tdata = d;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		joints_sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 30);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input pjvs_pkg::reg_idx_t idx, input logic [16:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wr_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Registers change only once the pipeline has drained.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic random_joints(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) send_joint(plausible_joint());
			else send_joint(noise_joint());
		end
	endtask

	initial begin
		logic [62:0] unit_i;
		logic [63:0] unit_q;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = pjvs_pkg::REG_STEP_TIME;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_off = 1'b0;
		burst_left = 0;
		joints_sent = 0;
		unit_i = {21'd32768, 21'd32768, 21'd32768};
		unit_q = 64'h0000_0000_0000_4000;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed joints under the reset settings.
		send_joint('0);
		send_joint(make_joint(unit_q, '0, '0, '0, rnd_vec(5000), rnd_vec(5000),
			'0, '0, '0, 32'hFFFF_FFFF));
		send_joint(make_joint(unit_q, rnd_vec(9000), rnd_vec(9000), rnd_vec(9000),
			rnd_vec(9000), rnd_vec(9000), unit_i, unit_i, unit_i, 32'h0001_0000));
		send_joint(make_joint(unit_q, rnd_vec(9000), '0, '0, rnd_vec(9000), rnd_vec(9000),
			unit_i, unit_i, unit_i, 32'd0));
		send_joint(make_joint(64'h7FFF_7FFF_7FFF_7FFF, {3{21'h0FFFFF}}, {3{21'h0FFFFF}},
			{3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h0FFFFF}}, {3{21'h0FFFFF}},
			{3{21'h0FFFFF}}, {3{21'h0FFFFF}}, 32'd1));
		send_joint(make_joint(64'h8000_8000_8000_8000, {3{21'h100000}}, {3{21'h100000}},
			{3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h100000}}, {3{21'h100000}},
			{3{21'h100000}}, {3{21'h100000}}, 32'd1));
		send_joint({600{1'b1}});
		send_joint(make_joint(64'h1234_0567_2000_3000, rnd_vec(50000), rnd_vec(50000),
			rnd_vec(50000), rnd_vec(50000), rnd_vec(50000), unit_i, unit_i, unit_i,
			32'h0000_0001));
		for (int i = 0; i < 8; i++) send_joint(plausible_joint());
		drain();

		// Extremes: zero step time, maximum stiffness, damping of exactly one.
		write_reg(pjvs_pkg::REG_STEP_TIME, 17'd0);
		write_reg(pjvs_pkg::REG_STIFFNESS, 17'd65535);
		write_reg(pjvs_pkg::REG_DAMPING, 17'd65536);
		// Index beyond the list must be ignored.
		cfg_wr_en = 1'b1;
		cfg_index = 2'd3;
		cfg_wr_data = 17'h1FFFF;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		send_joint(plausible_joint());
		send_joint(noise_joint());
		random_joints(150);
		drain();

		write_reg(pjvs_pkg::REG_STEP_TIME, 17'd65535);
		write_reg(pjvs_pkg::REG_STIFFNESS, 17'd0);
		write_reg(pjvs_pkg::REG_DAMPING, 17'h1FFFF);
		random_joints(140);
		// Long receiver hold-off while joints keep coming, so the input stalls.
		hold_off = 1'b1;
		random_joints(150);
		drain();

		write_reg(pjvs_pkg::REG_STEP_TIME, 17'd1);
		write_reg(pjvs_pkg::REG_STIFFNESS, 17'd26214);
		write_reg(pjvs_pkg::REG_DAMPING, 17'd0);
		random_joints(60);
		drain();

		write_reg(pjvs_pkg::REG_STEP_TIME, 17'($urandom_range(1, 65535)));
		write_reg(pjvs_pkg::REG_STIFFNESS, 17'($urandom_range(0, 65535)));
		write_reg(pjvs_pkg::REG_DAMPING, 17'($urandom_range(60000, 65536)));
		random_joints(110);
		drain();

		$display("Sent %0d joints over five register settings; %0d results checked, %0d faults.",
			joints_sent, result_count, fault_count);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
